/* hw/rtl/reply_line_assembler_classifier_defines.svh */
// Assertion macros shared by the reply line assembler RTL.
// Included by the top level; depends on nothing else.
`ifndef REPLY_LINE_ASSEMBLER_CLASSIFIER_DEFINES_SVH
`define REPLY_LINE_ASSEMBLER_CLASSIFIER_DEFINES_SVH

// Assert an implication on the rising clock edge, off during reset.
`define RLAC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a condition that must hold at every rising clock edge.
`define RLAC_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

/* hw/rtl/rlac_pkg.sv */
// Shared types and constants of the reply line assembler and classifier.
// No dependencies.
`default_nettype none
package rlac_pkg;
  localparam int unsigned LineBytes = 96;
  localparam int unsigned AddrW = $clog2(LineBytes);
  localparam int unsigned FillW = $clog2(LineBytes + 1);

  localparam logic [1:0] VerdictNone   = 2'd0;
  localparam logic [1:0] VerdictAccept = 2'd1;
  localparam logic [1:0] VerdictReject = 2'd2;

  localparam logic [10:0] ThresholdReset = 11'd750;

  // Commands from controller to datapath.
  typedef struct packed {
    logic store;       // write byte and bump fill
    logic drop;        // clear fill before store
    logic scan_start;  // clear scan state, latch line end info
    logic scan_step;   // process one byte at scan pointer
    logic rd_issue;    // present read address
    logic finish;      // evaluate and load result register
    logic bracket;
  } rlac_cmd_t;

  typedef struct packed {
    logic scan_last;   // scan pointer reached the end
    logic fill_zero;
    logic fill_full;
  } rlac_sts_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/rlac_datapath.sv */
// Line buffer, byte-serial scanner with keyword matchers and score parser.
// Depends on rlac_pkg.
`default_nettype none
module rlac_datapath import rlac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rlac_cmd_t             cmd_i,
  output rlac_sts_t             sts_o,
  input  logic [7:0]            rx_byte_i,
  input  logic [10:0]           pass_threshold_i,
  output logic [1:0]            verdict_o,
  output logic                  decided_by_score_o,
  output logic                  score_found_o,
  output logic [10:0]           score_milli_o,
  output logic [6:0]            line_length_o,
  output logic                  closed_by_bracket_o
);
  // Parser phases for keyed and comma forms.
  typedef enum logic [2:0] {PhGap1, PhSep, PhGap2, PhInt, PhFrac, PhDone} ph_e;

  logic [7:0] mem_q [LineBytes];
  logic [7:0] rd_q;
  logic [FillW-1:0] fill_q, fill_d, len_q, ptr_q;
  logic [7:0] wbyte;

  assign wbyte = (rx_byte_i < 8'h20 && rx_byte_i != 8'h09) ? 8'h3f : rx_byte_i;
  assign fill_d = cmd_i.drop ? '0 : fill_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem_q[fill_d[AddrW-1:0]] <= wbyte;
    if (cmd_i.rd_issue) rd_q <= mem_q[ptr_q[AddrW-1:0]];
  end

  // A closing bracket stores and starts the scan together; the line is done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.scan_start) begin
      fill_q <= '0;
    end else if (cmd_i.store) begin
      fill_q <= fill_d + 1'b1;
    end
  end

  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.fill_full = (fill_q >= FillW'(LineBytes - 1));
  assign sts_o.scan_last = (ptr_q >= len_q);

  // Keyword shift history: last 6 folded bytes.
  logic [7:0] h_q [6];
  logic [7:0] c;
  logic kw_pass_q, kw_succ_q, kw_ok_q, kw_allow_q;
  logic kw_fail_q, kw_deny_q, kw_err_q, kw_tmo_q;
  logic keyed_q, key_hit;
  logic [FillW-1:0] key_pos_q, comma_pos_q;
  logic comma_q;
  assign c = fold(rd_q);
  assign key_hit = {h_q[3], h_q[2], h_q[1], h_q[0], c} == "score";

  // Second pass state: parse from start position.
  logic pass2_q;
  ph_e ph_q;
  logic fail_q, digit_q;
  logic [9:0] ip_q;
  logic [9:0] fp_q;
  logic [1:0] nfrac_q;
  logic [FillW-1:0] start_pos;
  logic is_dig, is_gap;
  logic [3:0] dv;
  assign start_pos = keyed_q ? key_pos_q : comma_pos_q;
  assign is_dig = rd_q >= 8'h30 && rd_q <= 8'h39;
  assign is_gap = rd_q == 8'h20 || rd_q == 8'h09;
  assign dv = 4'(rd_q - 8'h30);

  logic [FillW-1:0] ptr_next;
  always_comb begin
    ptr_next = ptr_q + 1'b1;
  end

  logic [7:0] byte_in;
  assign byte_in = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0; len_q <= '0; pass2_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      ptr_q <= '0; len_q <= fill_d + FillW'(cmd_i.store); pass2_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (!pass2_q && ptr_q + 1'b1 >= len_q) begin
        pass2_q <= 1'b1;
        ptr_q <= keyed_q || key_hit ? (key_hit && !keyed_q ? ptr_q + 1'b1 : key_pos_q)
                 : (rd_q == 8'h2c ? ptr_q + 1'b1 : comma_pos_q);
      end else begin
        ptr_q <= ptr_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      for (int k = 0; k < 6; k++) h_q[k] <= 8'h00;
      {kw_pass_q, kw_succ_q, kw_ok_q, kw_allow_q} <= '0;
      {kw_fail_q, kw_deny_q, kw_err_q, kw_tmo_q} <= '0;
      keyed_q <= 1'b0; comma_q <= 1'b0;
      key_pos_q <= '0; comma_pos_q <= '0;
      ph_q <= PhGap1; fail_q <= 1'b0; digit_q <= 1'b0;
      ip_q <= '0; fp_q <= '0; nfrac_q <= '0;
    end else if (cmd_i.scan_step && !pass2_q) begin
      for (int k = 5; k > 0; k--) h_q[k] <= h_q[k-1];
      h_q[0] <= c;
      if ({h_q[2], h_q[1], h_q[0], c} == "pass") kw_pass_q <= 1'b1;
      if ({h_q[5], h_q[4], h_q[3], h_q[2], h_q[1], h_q[0], c} == "success")
        kw_succ_q <= 1'b1;
      if ({h_q[0], c} == "ok") kw_ok_q <= 1'b1;
      if ({h_q[3], h_q[2], h_q[1], h_q[0], c} == "allow") kw_allow_q <= 1'b1;
      if ({h_q[2], h_q[1], h_q[0], c} == "fail") kw_fail_q <= 1'b1;
      if ({h_q[2], h_q[1], h_q[0], c} == "deny") kw_deny_q <= 1'b1;
      if ({h_q[3], h_q[2], h_q[1], h_q[0], c} == "error") kw_err_q <= 1'b1;
      if ({h_q[5], h_q[4], h_q[3], h_q[2], h_q[1], h_q[0], c} == "timeout")
        kw_tmo_q <= 1'b1;
      if (key_hit && !keyed_q) begin
        keyed_q <= 1'b1; key_pos_q <= ptr_q + 1'b1;
      end
      if (rd_q == 8'h2c) begin
        comma_q <= 1'b1; comma_pos_q <= ptr_q + 1'b1;
      end
      // Keyed form with no following byte parses an end mark.
      if (ptr_q + 1'b1 >= len_q) begin
        if (keyed_q || key_hit) ph_q <= PhGap1;
        else if (!(comma_q || rd_q == 8'h2c)) begin
          ph_q <= PhDone; fail_q <= 1'b1;
        end
      end
    end else if (cmd_i.scan_step && pass2_q && ph_q != PhDone) begin
      unique case (ph_q)
        PhGap1: if (!is_gap) begin
          if (keyed_q) begin
            if (byte_in == 8'h3d || byte_in == 8'h3a) ph_q <= PhGap2;
            else begin ph_q <= PhDone; fail_q <= 1'b1; end
          end else begin
            ph_q <= PhInt;
            // reprocess as integer phase below
            if (is_dig) begin
              digit_q <= 1'b1;
              if (ip_q < 10'd100) ip_q <= 10'(ip_q * 4'd10 + dv);
            end else if (byte_in == 8'h2e) ph_q <= PhFrac;
            else ph_q <= PhDone;
          end
        end
        PhSep: ph_q <= PhDone;
        PhGap2: if (!is_gap) begin
          if (is_dig) begin
            ph_q <= PhInt; digit_q <= 1'b1;
            ip_q <= 10'(dv);
          end else if (byte_in == 8'h2e) ph_q <= PhFrac;
          else ph_q <= PhDone;
        end
        PhInt: begin
          if (is_dig) begin
            digit_q <= 1'b1;
            if (ip_q < 10'd100) ip_q <= 10'(ip_q * 4'd10 + dv);
          end else if (byte_in == 8'h2e) ph_q <= PhFrac;
          else ph_q <= PhDone;
        end
        PhFrac: begin
          if (is_dig) begin
            if (nfrac_q < 2'd3) begin
              fp_q <= 10'(fp_q * 4'd10 + dv);
              nfrac_q <= nfrac_q + 1'b1; digit_q <= 1'b1;
            end
          end else ph_q <= PhDone;
        end
        default: ph_q <= PhDone;
      endcase
    end
  end

  // Scale fraction by remaining power of ten.
  logic [10:0] frac_ms, score_c;
  logic found_c;
  always_comb begin
    case (nfrac_q)
      2'd0: frac_ms = '0;
      2'd1: frac_ms = 11'(fp_q * 7'd100);
      2'd2: frac_ms = 11'(fp_q * 4'd10);
      default: frac_ms = 11'(fp_q);
    endcase
    found_c = !fail_q && digit_q && ip_q <= 10'd1;
    score_c = found_c ? (ip_q[0] ? 11'd1000 : 11'd0) + frac_ms : 11'd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      score_found_o <= found_c;
      score_milli_o <= score_c;
      line_length_o <= 7'(len_q);
      closed_by_bracket_o <= cmd_i.bracket;
      decided_by_score_o <= 1'b0;
      if (found_c && score_c >= pass_threshold_i) begin
        verdict_o <= VerdictAccept; decided_by_score_o <= 1'b1;
      end else if (kw_pass_q || kw_succ_q || kw_ok_q || kw_allow_q)
        verdict_o <= VerdictAccept;
      else if (kw_fail_q || kw_deny_q || kw_err_q || kw_tmo_q)
        verdict_o <= VerdictReject;
      else verdict_o <= VerdictNone;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/rlac_ctrl.sv */
// Controller: byte intake, two-pass line scan sequencing, result handshake.
// Depends on rlac_pkg.
`default_nettype none
module rlac_ctrl import rlac_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rlac_cmd_t cmd_o,
  input  rlac_sts_t sts_i
);
  typedef enum logic [4:0] {
    StIdle = 5'b00001, StRead = 5'b00010, StStep = 5'b00100,
    StEval = 5'b01000, StOut = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic br_q, br_d, ovalid_q, ovalid_d;
  logic acc, is_eol, is_br;

  assign in_stall_o = (state_q != StIdle);
  assign acc = in_valid_i && !in_stall_o;
  assign is_eol = rx_byte_i == 8'h0d || rx_byte_i == 8'h0a;
  assign is_br = rx_byte_i == 8'h5d;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q; br_d = br_q; ovalid_d = ovalid_q;
    cmd_o = '0;
    cmd_o.bracket = br_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: if (acc) begin
        if (!is_eol) begin
          cmd_o.store = 1'b1;
          cmd_o.drop = sts_i.fill_full;
        end
        if ((is_eol && !sts_i.fill_zero) || is_br) begin
          cmd_o.scan_start = 1'b1; br_d = is_br; state_d = StRead;
        end
      end
      StRead: begin cmd_o.rd_issue = 1'b1; state_d = StStep; end
      StStep: begin
        if (sts_i.scan_last) state_d = StEval;
        else begin cmd_o.scan_step = 1'b1; state_d = StRead; end
      end
      // Hold until the previous result has left the output register.
      StEval: if (!ovalid_q) begin cmd_o.finish = 1'b1; state_d = StOut; end
      StOut: if (!ovalid_q) begin ovalid_d = 1'b1; state_d = StIdle; end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; br_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; br_q <= br_d; ovalid_q <= ovalid_d;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/reply_line_assembler_classifier.sv */
// Reply line assembler and classifier. Buffers one byte per item and, at
// line end, scans the stored line once for keywords, then parses the score
// from its start point. The scan reads the single-port line buffer one byte
// at a time, alternating a read state and a step state. Input is stalled
// during a scan, and a finished line waits while an earlier result is still
// held.
`default_nettype none
`include "reply_line_assembler_classifier_defines.svh"
module reply_line_assembler_classifier import rlac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic        decided_by_score_o,
  output logic        score_found_o,
  output logic [10:0] score_milli_o,
  output logic [6:0]  line_length_o,
  output logic        closed_by_bracket_o
);
  logic [10:0] thr_q;
  rlac_cmd_t cmd;
  rlac_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= ThresholdReset;
    else if (cfg_we_i) thr_q <= cfg_wdata_i;
  end

  rlac_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .rx_byte_i,
    .out_valid_o, .out_stall_i, .cmd_o(cmd), .sts_i(sts)
  );

  rlac_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .rx_byte_i,
    .pass_threshold_i(thr_q), .verdict_o, .decided_by_score_o,
    .score_found_o, .score_milli_o, .line_length_o, .closed_by_bracket_o
  );

  `RLAC_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(verdict_o) &&
    $stable(score_milli_o) && $stable(line_length_o)), "result changed while stalled")
  `RLAC_ALWAYS(a_verdict_code, clk_i, rst_ni,
    !out_valid_o || verdict_o <= VerdictReject, "bad verdict")
  `RLAC_ASSERT(a_by_score, clk_i, rst_ni,
    (out_valid_o && decided_by_score_o) |-> (score_found_o && verdict_o == VerdictAccept),
    "score decision inconsistent")
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Testbench for reply_line_assembler_classifier: drives received bytes, predicts
// each finished line's verdict and score, and checks every result.
// Depends on rlac_pkg and the RTL top level only.
module testbench;
  import rlac_pkg::*;

  localparam int unsigned MaxCycles = 4000000;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        by_score;
    logic        found;
    logic [10:0] milli;
    logic [6:0]  length;
    logic        bracket;
  } line_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  verdict_o;
  logic        decided_by_score_o;
  logic        score_found_o;
  logic [10:0] score_milli_o;
  logic [6:0]  line_length_o;
  logic        closed_by_bracket_o;

  reply_line_assembler_classifier dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .rx_byte_i(rx_byte_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .verdict_o(verdict_o),
    .decided_by_score_o(decided_by_score_o), .score_found_o(score_found_o),
    .score_milli_o(score_milli_o), .line_length_o(line_length_o),
    .closed_by_bracket_o(closed_by_bracket_o)
  );

  // Predictor state
  logic [7:0]   line_buf [LineBytes];
  int unsigned  line_len;
  logic [10:0]  threshold;
  line_result_t verdict_queue [$];

  int unsigned  errors;
  int unsigned  lines_checked;
  int unsigned  bytes_sent;
  int unsigned  cycle_count;
  bit           hold_off;
  bit           quiet_sender;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] byte_at(input int unsigned i);
    return (i < line_len) ? line_buf[i] : 8'h00;
  endfunction

  function automatic bit contains(input string w);
    int unsigned i, j;
    bit hit;
    for (i = 0; i + w.len() <= line_len; i++) begin
      hit = 1'b1;
      for (j = 0; j < w.len(); j++)
        if (lower(byte_at(i + j)) != w[j]) hit = 1'b0;
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit parse_score(output int unsigned milli);
    int unsigned pos, i, ip, fp, base, nfrac;
    bit keyed, found, digit;
    pos = 0; ip = 0; fp = 0; base = 1000; nfrac = 0;
    keyed = 0; found = 0; digit = 0; milli = 0;
    for (i = 0; i + 4 < line_len && !found; i++)
      if (lower(byte_at(i)) == "s" && lower(byte_at(i + 1)) == "c" &&
          lower(byte_at(i + 2)) == "o" && lower(byte_at(i + 3)) == "r" &&
          lower(byte_at(i + 4)) == "e") begin
        pos = i + 5; keyed = 1; found = 1;
      end
    if (!found) begin
      for (i = 0; i < line_len; i++)
        if (byte_at(i) == ",") begin
          pos = i + 1; found = 1;
        end
      if (!found) return 1'b0;
    end
    while (byte_at(pos) == " " || byte_at(pos) == 8'h09) pos++;
    if (keyed) begin
      if (byte_at(pos) != "=" && byte_at(pos) != ":") return 1'b0;
      pos++;
      while (byte_at(pos) == " " || byte_at(pos) == 8'h09) pos++;
    end
    while (is_digit(byte_at(pos))) begin
      digit = 1;
      if (ip < 100) ip = ip * 10 + (byte_at(pos) - "0");
      pos++;
    end
    if (byte_at(pos) == ".") begin
      pos++;
      while (is_digit(byte_at(pos)) && nfrac < 3) begin
        fp = fp * 10 + (byte_at(pos) - "0");
        nfrac++; base /= 10; pos++; digit = 1;
      end
      while (is_digit(byte_at(pos))) pos++;
    end
    if (!digit || ip > 1) return 1'b0;
    milli = ip * 1000 + fp * base;
    return 1'b1;
  endfunction

  function automatic void close_line(input bit bracket);
    line_result_t r;
    int unsigned score;
    bit found;
    found = parse_score(score);
    if (!found) score = 0;
    r = '0;
    r.verdict = VerdictNone;
    if (found && score >= threshold) begin
      r.verdict = VerdictAccept;
      r.by_score = 1'b1;
    end else if (contains("pass") || contains("success") || contains("ok") ||
                 contains("allow")) begin
      r.verdict = VerdictAccept;
    end else if (contains("fail") || contains("deny") || contains("error") ||
                 contains("timeout")) begin
      r.verdict = VerdictReject;
    end
    r.found = found;
    r.milli = score[10:0];
    r.length = line_len[6:0];
    r.bracket = bracket;
    verdict_queue.push_back(r);
    line_len = 0;
  endfunction

  function automatic void predict_byte(input logic [7:0] c);
    if (c == 8'h0d || c == 8'h0a) begin
      if (line_len > 0) close_line(1'b0);
      return;
    end
    if (line_len >= LineBytes - 1) line_len = 0;
    line_buf[line_len] = (c < 8'h20 && c != 8'h09) ? "?" : c;
    line_len++;
    if (c == "]") close_line(1'b1);
  endfunction

  // Send one byte; burst gaps are drawn here so they land on any phase.
  // Valid stays up between bytes of a burst and drops only for a gap or in drain().
  task automatic send_byte(input logic [7:0] c);
    int unsigned gap;
    if (!quiet_sender && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(c);
    bytes_sent++;
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Wait for all lines to drain, then let the block settle before a write.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (verdict_queue.size() != 0) @(posedge clk_i);
    repeat (4 * LineBytes + 20) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [10:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    threshold = v;
  endtask

  // Receiver stalls on its own pattern; a long hold-off overrides it.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (cycle_count[9:8] == 2'b11) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    line_result_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {verdict_o, decided_by_score_o, score_found_o, score_milli_o,
             line_length_o, closed_by_bracket_o};
      if (verdict_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = verdict_queue.pop_front();
        lines_checked++;
        if (got.verdict != want.verdict) begin
          $display("%0t: verdict exp %0d got %0d", $time, want.verdict, got.verdict);
          errors++;
        end
        if (got.by_score != want.by_score) begin
          $display("%0t: by_score exp %0d got %0d", $time, want.by_score, got.by_score);
          errors++;
        end
        if (got.found != want.found) begin
          $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
          errors++;
        end
        if (got.milli != want.milli) begin
          $display("%0t: score exp %0d got %0d", $time, want.milli, got.milli);
          errors++;
        end
        if (got.length != want.length) begin
          $display("%0t: length exp %0d got %0d", $time, want.length, got.length);
          errors++;
        end
        if (got.bracket != want.bracket) begin
          $display("%0t: bracket exp %0d got %0d", $time, want.bracket, got.bracket);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_chars("\n");                       // empty line is ignored
    send_chars("score=1.5\n");
    send_chars("SCORE : 0.75]");
    send_chars("Score 0.9 ok\r");           // missing separator, keyword decides
    send_chars("result,  0.7499\n");
    send_chars("a,1,0.8123\n");
    send_chars("score=2.0 pass\n");         // integer part too large
    send_chars("score=999999999 fail\n");   // integer part saturates
    send_chars("score=129\n");
    send_chars("PASS\n");
    send_chars("Success\n");
    send_chars("allow\n");
    send_chars("Fail\n");
    send_chars("deny\n");
    send_chars("ERROR\n");
    send_chars("timeout\n");
    send_chars("nothing\n");
    send_chars("score=.\n");
    send_chars("x,1.\n");
    send_byte(8'h00); send_byte(8'h09); send_byte(8'h1f); send_byte(8'hff);
    send_chars("\n");
    repeat (100) send_byte("z");           // overflow drops the partial line
    send_chars("]");
    repeat (95) send_byte("y");            // full buffer, then a closing bracket
    send_chars("]");
  endtask

  task automatic test_thresholds();
    write_threshold(11'd0);
    send_chars("score=0\n");
    send_chars("abc\n");
    write_threshold(11'd2047);
    send_chars("score:1.999 error\n");
    write_threshold(11'd1000);
    send_chars("x, 1\n");
    send_chars("x, 0.999\n");
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return ",";
      2: return ".";
      3: return " ";
      4: return $urandom_range(0, 1) ? "=" : ":";
      5, 6: return 8'("0" + $urandom_range(0, 9));
      default: return 8'("a" + $urandom_range(0, 25) - ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    endcase
  endfunction

  function automatic string maybe(input string a);
    string empty;
    empty = "";
    return $urandom_range(0, 1) ? a : empty;
  endfunction

  function automatic string rand_number();
    string s;
    s = $urandom_range(0, 3) == 0 ? $sformatf("%0d", $urandom_range(0, 300)) :
        $sformatf("%0d", $urandom_range(0, 1));
    if ($urandom_range(0, 2) != 0) begin
      s = {s, "."};
      repeat ($urandom_range(0, 5)) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    end
    return s;
  endfunction

  task automatic test_random_lines(input int unsigned n_bytes);
    string words[10];
    string s;
    int unsigned start;
    words = '{"pass", "SUCCESS", "Ok", "allow", "fail", "Deny", "error", "TimeOut",
              "score", "sc0re"};
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      s = "";
      repeat ($urandom_range(0, 6)) s = {s, string'(rand_char())};
      case ($urandom_range(0, 3))
        0: s = {s, "score", maybe(" "), $urandom_range(0, 1) ? "=" : ":",
                maybe("\t"), rand_number()};
        1: s = {s, ",", maybe(" "), rand_number()};
        2: s = {s, " ", words[$urandom_range(0, 9)]};
        default: ;
      endcase
      repeat ($urandom_range(0, 4)) s = {s, string'(rand_char())};
      if ($urandom_range(0, 3) == 0) s = {s, " ", words[$urandom_range(0, 9)]};
      if ($urandom_range(0, 30) == 0)
        repeat ($urandom_range(80, 120)) s = {s, string'(rand_char())};
      case ($urandom_range(0, 3))
        0: s = {s, "]"};
        1: s = {s, "\r"};
        default: s = {s, "\n"};
      endcase
      send_chars(s);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        quiet_sender = 1'b1;
        repeat (6) send_chars("ok\n");
        quiet_sender = 1'b0;
        drain();
      end
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
  endtask

  initial begin
    errors = 0; lines_checked = 0; bytes_sent = 0; cycle_count = 0;
    hold_off = 1'b0; quiet_sender = 1'b0;
    line_len = 0; threshold = ThresholdReset;
    cfg_we_i = 1'b0; cfg_wdata_i = '0; in_valid_i = 1'b0; rx_byte_i = '0;
    out_stall_i = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_thresholds();
    write_threshold(11'd750);
    test_backpressure();
    test_random_lines(500);
    write_threshold(11'd500);
    test_random_lines(300);
    write_threshold(11'd1999);
    test_random_lines(300);
    drain();

    $display("sent %0d bytes, checked %0d lines over thresholds 0..2047", bytes_sent,
             lines_checked);
    $display("covered score/comma parsing, keywords, control bytes, overflow, stalls");
    if (errors == 0 && verdict_queue.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

/* reply_line_assembler_classifier.f */
+incdir+hw/rtl
hw/rtl/rlac_pkg.sv
hw/rtl/rlac_datapath.sv
hw/rtl/rlac_ctrl.sv
hw/rtl/reply_line_assembler_classifier.sv
tb/testbench.sv
